FILE: design/wildcard_pattern_matcher_top_defines.svh
// Assertion macros used by the wildcard pattern matcher top level.
`ifndef WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define WPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wildcard matcher same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wildcard matcher next-cycle check failed");

`endif

FILE: design/wpm_pkg.sv
// Shared types and constants of the wildcard pattern matcher.
package wpm_pkg;

   // Input item modes.
   localparam logic [1:0] MODE_PATTERN = 2'd0;
   localparam logic [1:0] MODE_TEXT    = 2'd1;
   localparam logic [1:0] MODE_REPORT  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_LATE_PATT = 2'd2;

   // Wildcard bytes.
   localparam logic [7:0] STAR_BYTE  = 8'h2A;
   localparam logic [7:0] QMARK_BYTE = 8'h3F;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_value;
   } req_type;

   typedef struct packed {
      logic       matched;
      logic [1:0] status;
   } rsp_type;

   // Per-cycle job control from the top level to the storage and engine.
   typedef struct packed {
      logic push;      // append the item byte to the pattern
      logic consume;   // step the position vector over the item byte
      logic clear;     // end of job: return to the empty job
   } job_ctl_type;

endpackage

FILE: design/wpm_pattern_store.sv
// Pattern byte storage, pattern length and per-position match flags.
module wpm_pattern_store #(
   parameter int MAX_PATTERN = 63,
   parameter int LEN_W       = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  wpm_pkg::job_ctl_type     ctl,
   input  logic [7:0]               char_value,
   output logic [LEN_W-1:0]         pattern_len,
   output logic [MAX_PATTERN-1:0]   star_vec,
   output logic [MAX_PATTERN-1:0]   adv_vec
);
   import wpm_pkg::*;

   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [7:0]       store_ff [MAX_PATTERN];
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;

   // Pattern bytes are written in order at the current length.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         store_ff[len_ff[ADDR_W-1:0]] <= char_value;
      end
   end

   // Length counts pushed bytes and returns to zero at the end of a job.
   always_comb begin
      len_in = len_ff;
      if (ctl.clear) begin
         len_in = '0;
      end else if (ctl.push) begin
         len_in = len_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   assign pattern_len = len_ff;

   // Each position decodes its own byte; positions past the end stay quiet.
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pos
      logic in_range;
      logic is_star;
      assign in_range = (LEN_W'(j) < len_ff);
      assign is_star  = (store_ff[j] == STAR_BYTE);
      assign star_vec[j] = in_range && is_star;
      assign adv_vec[j]  = in_range && !is_star &&
                           ((store_ff[j] == QMARK_BYTE) || (store_ff[j] == char_value));
   end

endmodule

FILE: design/wpm_position_engine.sv
// Reachable position vector with star closure and one-byte step.
module wpm_position_engine #(
   parameter int MAX_PATTERN = 63,
   parameter int LEN_W       = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  wpm_pkg::job_ctl_type     ctl,
   input  logic [LEN_W-1:0]         pattern_len,
   input  logic [MAX_PATTERN-1:0]   star_vec,
   input  logic [MAX_PATTERN-1:0]   adv_vec,
   output logic                     hit
);
   import wpm_pkg::*;

   localparam int W    = MAX_PATTERN + 1;
   localparam int LVLS = $clog2(W);

   logic [W-1:0] reach_ff;
   logic [W-1:0] reach_in;
   logic [W-1:0] closed;
   logic [W-1:0] stepped;
   logic [LVLS:0][W-1:0] gen_lvl;
   logic [LVLS:0][W-1:0] prop_lvl;

   // Star closure as a parallel prefix: a reachable position reaches every
   // position behind an unbroken run of stars.
   always_comb begin
      int sh;
      gen_lvl[0]  = reach_ff;
      prop_lvl[0] = {star_vec, 1'b0};
      for (int d = 0; d < LVLS; d++) begin
         sh = 1 << d;
         for (int j = 0; j < W; j++) begin
            if (j >= sh) begin
               gen_lvl[d+1][j]  = gen_lvl[d][j] | (prop_lvl[d][j] & gen_lvl[d][j-sh]);
               prop_lvl[d+1][j] = prop_lvl[d][j] & prop_lvl[d][j-sh];
            end else begin
               gen_lvl[d+1][j]  = gen_lvl[d][j];
               prop_lvl[d+1][j] = prop_lvl[d][j];
            end
         end
      end
      closed = gen_lvl[LVLS];
   end

   // A star keeps its position; a literal or question mark match advances.
   always_comb begin
      stepped = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if (closed[j] && star_vec[j]) begin
            stepped[j] = 1'b1;
         end
         if (closed[j] && adv_vec[j]) begin
            stepped[j+1] = 1'b1;
         end
      end
   end

   assign hit = closed[pattern_len];

   always_comb begin
      reach_in = reach_ff;
      if (ctl.clear) begin
         reach_in = W'(1);
      end else if (ctl.consume) begin
         reach_in = stepped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= W'(1);
      end else begin
         reach_ff <= reach_in;
      end
   end

endmodule

FILE: design/wildcard_pattern_matcher_top.sv
// Top level of the wildcard pattern matcher: input register, job control,
// result register.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  wpm_pkg::req_type (mode, char_value)
//   rsp_     out        rsp_valid/rsp_stall  wpm_pkg::rsp_type (matched, status)
//
// One item per cycle while req_stall is low: each transfer lands in the
// input register and is applied from there through the star-closure prefix
// network of the position engine. A report item shows its result in the cycle
// after it is applied. Reset clears the job state; no clearing pass is needed.
// A report waits in the input register only while the result register is held
// by rsp_stall; pattern and text bytes go on regardless.
`include "wildcard_pattern_matcher_top_defines.svh"

module wildcard_pattern_matcher_top #(
   parameter int MAX_PATTERN = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wpm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wpm_pkg::rsp_type  rsp_data
);
   import wpm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

   logic                   in_valid_ff;
   req_type                in_data_ff;
   logic                   text_started_ff;
   logic                   text_started_in;
   logic [1:0]             err_ff;
   logic [1:0]             err_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;
   logic                   accept;
   logic                   advance;
   logic                   is_pattern;
   logic                   is_text;
   logic                   is_report;
   logic                   hit;
   logic [LEN_W-1:0]       pattern_len;
   logic [MAX_PATTERN-1:0] star_vec;
   logic [MAX_PATTERN-1:0] adv_vec;
   job_ctl_type            ctl;

   assign is_pattern = (in_data_ff.mode == MODE_PATTERN);
   assign is_text    = (in_data_ff.mode == MODE_TEXT);
   assign is_report  = (in_data_ff.mode == MODE_REPORT);

   // A held item moves on unless it is a report facing a stalled result.
   assign advance   = in_valid_ff && !(is_report && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   // Job control for the storage and the engine.
   always_comb begin
      ctl.push    = advance && is_pattern && !text_started_ff && (pattern_len < MAX_LEN);
      ctl.consume = advance && is_text;
      ctl.clear   = advance && is_report;
   end

   // Text flag and first-error capture.
   always_comb begin
      text_started_in = text_started_ff;
      err_in          = err_ff;
      if (ctl.clear) begin
         text_started_in = 1'b0;
         err_in          = STATUS_OK;
      end else if (ctl.consume) begin
         text_started_in = 1'b1;
      end else if (advance && is_pattern && (err_ff == STATUS_OK)) begin
         if (text_started_ff) begin
            err_in = STATUS_LATE_PATT;
         end else if (pattern_len >= MAX_LEN) begin
            err_in = STATUS_OVERFLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_started_ff <= 1'b0;
         err_ff          <= STATUS_OK;
      end else begin
         text_started_ff <= text_started_in;
         err_ff          <= err_in;
      end
   end

   wpm_pattern_store #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .char_value  (in_data_ff.char_value),
      .pattern_len (pattern_len),
      .star_vec    (star_vec),
      .adv_vec     (adv_vec)
   );

   wpm_position_engine #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .pattern_len (pattern_len),
      .star_vec    (star_vec),
      .adv_vec     (adv_vec),
      .hit         (hit)
   );

   // Result register: loaded by a report, emptied by a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         rsp_data_ff.matched <= hit && (err_ff == STATUS_OK);
         rsp_data_ff.status  <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result with an error never claims a match.
   `WPM_ASSERT_NOW(a_err_no_match, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK), !rsp_data_ff.matched)

   // A report leaves an empty job behind.
   `WPM_ASSERT_NEXT(a_report_clears, clock, reset, ctl.clear,
      (pattern_len == '0) && !text_started_ff && (err_ff == STATUS_OK))

   // The first error is kept until the report.
   `WPM_ASSERT_NEXT(a_err_sticky, clock, reset, (err_ff != STATUS_OK) && !ctl.clear,
      err_ff == $past(err_ff))

endmodule

FILE: tb/wildcard_pattern_matcher_top_test.sv
// Self-checking testbench of the wildcard pattern matcher top level.
`timescale 1ns / 100ps

module wildcard_pattern_matcher_top_test;
   import wpm_pkg::*;

   localparam int MAX_PATTERN    = 63;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_ITEMS   = 1300;

   // Mode 3 has no meaning; the block must ignore it.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shared run control.
   bit idle_enable = 1'b1;
   int hold_asked  = 0;
   int fail_count  = 0;
   int items_sent  = 0;

   // Predicted verdicts in the order the reports were accepted.
   rsp_type pending_verdicts[$];

   // Predictor copy of the job state.
   logic [7:0]  pat_bytes[MAX_PATTERN];
   int          pat_len        = 0;
   logic [63:0] live_positions = 64'd1;
   bit          text_seen      = 1'b0;
   logic [1:0]  job_error      = STATUS_OK;

   wildcard_pattern_matcher_top #(
      .MAX_PATTERN(MAX_PATTERN)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Adds every position reached by letting a star match the empty run.
   function automatic logic [63:0] close_over_stars(input logic [63:0] v);
      for (int j = 0; j < pat_len; j++) begin
         if (v[j] && pat_bytes[j] == STAR_BYTE) v[j + 1] = 1'b1;
      end
      return v;
   endfunction

   // Advances the job state over one accepted item and queues any verdict.
   function automatic void track_matcher_item(input req_type item);
      logic [63:0] cur;
      logic [63:0] nxt;
      rsp_type     verdict;
      case (item.mode)
         MODE_PATTERN: begin
            if (text_seen) begin
               if (job_error == STATUS_OK) job_error = STATUS_LATE_PATT;
            end else if (pat_len >= MAX_PATTERN) begin
               if (job_error == STATUS_OK) job_error = STATUS_OVERFLOW;
            end else begin
               pat_bytes[pat_len] = item.char_value;
               pat_len++;
            end
         end
         MODE_TEXT: begin
            text_seen = 1'b1;
            cur = close_over_stars(live_positions);
            nxt = '0;
            for (int j = 0; j < pat_len; j++) begin
               if (cur[j]) begin
                  if (pat_bytes[j] == STAR_BYTE) nxt[j] = 1'b1;
                  else if (pat_bytes[j] == QMARK_BYTE || pat_bytes[j] == item.char_value)
                     nxt[j + 1] = 1'b1;
               end
            end
            live_positions = nxt;
         end
         MODE_REPORT: begin
            cur = close_over_stars(live_positions);
            verdict.matched = cur[pat_len] && (job_error == STATUS_OK);
            verdict.status  = job_error;
            pending_verdicts.push_back(verdict);
            pat_len        = 0;
            live_positions = 64'd1;
            text_seen      = 1'b0;
            job_error      = STATUS_OK;
         end
         default: ;
      endcase
   endfunction

   // Offers one item, optionally after an idle burst, and waits for its transfer.
   task automatic send_item(input logic [1:0] mode, input logic [7:0] value);
      req_type item;
      int      gap;
      item.mode       = mode;
      item.char_value = value;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      track_matcher_item(item);
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   // Stops offering items and waits until every predicted verdict has arrived.
   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // Receiver: checks each result transfer and drives random or long stalls.
   int stall_left = 0;
   int hold_left  = 0;
   int hold_done  = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: matched=%0b status=%0d",
                        rsp_data.matched, rsp_data.status);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.matched !== want.matched || rsp_data.status !== want.status) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result check failed: expected matched=%0b status=%0d, got matched=%0b status=%0d",
                           want.matched, want.status, rsp_data.matched, rsp_data.status);
            end
         end
      end
      if (hold_asked != hold_done) begin
         hold_left = LONG_HOLD;
         hold_done = hold_done + 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Pattern bytes lean on wildcards and a tiny alphabet so matches are common.
   function automatic logic [7:0] random_pattern_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return STAR_BYTE;
         3, 4:    return QMARK_BYTE;
         5, 6, 7: return ($urandom_range(0, 1) == 0) ? "a" : "b";
         8:       return 8'($urandom_range(0, 255));
         default: return "c";
      endcase
   endfunction

   function automatic logic [7:0] random_text_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return "a";
         3, 4:    return "b";
         5, 6:    return "c";
         7:       return STAR_BYTE;
         8:       return QMARK_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One job: a pattern, a text built to fit it and often spoiled, then a report.
   task automatic random_job();
      logic [7:0] patt[$];
      logic [7:0] txt[$];
      int         plen;
      int         run;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) plen = $urandom_range(MAX_PATTERN - 3, MAX_PATTERN + 3);
      else if (pick < 12) plen = $urandom_range(9, 40);
      else plen = $urandom_range(0, 8);
      for (int i = 0; i < plen; i++) patt.push_back(random_pattern_byte());
      for (int i = 0; i < plen && i < MAX_PATTERN; i++) begin
         if (patt[i] == STAR_BYTE) begin
            run = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 3);
            for (int k = 0; k < run; k++) txt.push_back(random_text_byte());
         end else if (patt[i] == QMARK_BYTE) begin
            txt.push_back(8'($urandom_range(0, 255)));
         end else begin
            txt.push_back(patt[i]);
         end
      end
      case ($urandom_range(0, 7))
         0: if (txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = random_text_byte();
         1: if (txt.size() > 0) void'(txt.pop_back());
         2: txt.push_back(random_text_byte());
         3: begin
            txt.delete();
            run = $urandom_range(0, 12);
            for (int k = 0; k < run; k++) txt.push_back(random_text_byte());
         end
         default: ;
      endcase
      foreach (patt[p]) begin
         if ($urandom_range(0, 39) == 0) send_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
         send_item(MODE_PATTERN, patt[p]);
      end
      foreach (txt[t]) send_item(MODE_TEXT, txt[t]);
      // Occasionally a pattern byte arrives after the text.
      if ($urandom_range(0, 19) == 0) send_item(MODE_PATTERN, random_pattern_byte());
      send_item(MODE_REPORT, 8'($urandom_range(0, 255)));
   endtask

   // Short burst of items of any mode in any order, closed by a report.
   task automatic noise_job();
      int count;
      count = $urandom_range(1, 10);
      for (int i = 0; i < count; i++)
         send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      send_item(MODE_REPORT, 8'($urandom_range(0, 255)));
   endtask

   // Named corner cases, byte extremes and every mode.
   task automatic test_directed();
      // Empty pattern against empty text, then against one byte.
      send_item(MODE_REPORT, 8'h00);
      send_item(MODE_TEXT, "a");
      send_item(MODE_REPORT, 8'hFF);
      // A star matches the empty text and also a text star.
      send_item(MODE_PATTERN, STAR_BYTE);
      send_item(MODE_REPORT, 8'h00);
      send_item(MODE_PATTERN, STAR_BYTE);
      send_item(MODE_TEXT, STAR_BYTE);
      send_item(MODE_REPORT, 8'h00);
      // A pattern byte after text sets the late-pattern status.
      send_item(MODE_PATTERN, "a");
      send_item(MODE_TEXT, "a");
      send_item(MODE_PATTERN, "b");
      send_item(MODE_REPORT, 8'h00);
      // An unused mode in the middle of a job changes nothing.
      send_item(MODE_PATTERN, "x");
      send_item(MODE_UNUSED, 8'hFF);
      send_item(MODE_TEXT, "x");
      send_item(MODE_REPORT, 8'h00);
      // Byte extremes, and text running past the end of the pattern.
      send_item(MODE_PATTERN, 8'hFF);
      send_item(MODE_TEXT, 8'hFF);
      send_item(MODE_REPORT, 8'hFF);
      send_item(MODE_PATTERN, 8'h00);
      send_item(MODE_TEXT, 8'h00);
      send_item(MODE_TEXT, 8'h00);
      send_item(MODE_REPORT, 8'h55);
   endtask

   // The receiver holds off while reports keep coming, so the input stalls.
   task automatic test_backpressure();
      hold_asked = hold_asked + 1;
      for (int i = 0; i < 12; i++) begin
         send_item(MODE_PATTERN, QMARK_BYTE);
         send_item(MODE_TEXT, 8'($urandom_range(0, 255)));
         send_item(MODE_REPORT, 8'h00);
      end
      pause_sender();
   endtask

   // Mostly well-formed jobs with random content, some noise and drain pauses.
   task automatic test_random_jobs();
      int goal;
      int pick;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            noise_job();
         end else if (pick < 9) begin
            pause_sender();
            random_job();
         end else begin
            random_job();
         end
      end
   endtask

   // Final stretch with neither side idling.
   task automatic test_steady_stream();
      idle_enable = 1'b0;
      for (int i = 0; i < 30; i++) random_job();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_jobs();
      test_steady_stream();
      pause_sender();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_verdicts.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/wpm_pkg.sv
design/wpm_pattern_store.sv
design/wpm_position_engine.sv
design/wildcard_pattern_matcher_top.sv
tb/wildcard_pattern_matcher_top_test.sv
